### hw/rtl/lcdws_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LCD write sequencer package
// Request codes, command bytes, register indexes and the bus write record
// passed from the front end to the event generator.
// ----------------------------------------------------------------------------
package lcdws_pkg;

  typedef enum logic [2:0] {
    OP_COMMAND = 3'd0,
    OP_DATA    = 3'd1,
    OP_GOTO    = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_INIT    = 3'd4,
    OP_CGRAM   = 3'd5,
    OP_NUMBER  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIGITS,
    FR_EMIT
  } front_state_t;

  localparam logic [1:0] CFG_ENABLE_HIGH = 2'd0;
  localparam logic [1:0] CFG_SETTLE      = 2'd1;
  localparam logic [1:0] CFG_CLEAR_EXTRA = 2'd2;

  localparam logic [7:0] ENABLE_HIGH_RESET = 8'd1;
  localparam logic [7:0] SETTLE_RESET      = 8'd2;
  localparam logic [7:0] CLEAR_EXTRA_RESET = 8'd2;

  localparam logic [3:0] ROW0_BASE_HI     = 4'h8;
  localparam logic [3:0] ROW1_BASE_HI     = 4'hC;
  localparam logic [1:0] CGRAM_BASE_HI    = 2'b01;
  localparam logic [7:0] CMD_SET_DDRAM    = 8'h80;
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] ASCII_ZERO       = 8'h30;

  localparam logic [7:0]  SCREEN_COLS  = 8'd16;
  localparam logic [7:0]  CGRAM_SLOTS  = 8'd8;
  localparam logic [2:0]  NUM_DIGITS   = 3'd5;
  localparam logic [16:0] DIV10_MUL    = 17'd52429;
  localparam int          DIV10_SHIFT  = 19;

  typedef struct packed {
    logic       rs;
    logic [7:0] data;
    logic       extra;
    logic       bad;
    logic       last;
  } wr_t;

endpackage
`default_nettype wire

### hw/rtl/char_lcd_write_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Character LCD write sequencer
// Converts 8-bit character LCD requests into timed pin events.
// ----------------------------------------------------------------------------
// Each request becomes up to nine bus writes and each write two pin events
// (enable high, then enable low), so a request yields up to 18 events; a goto
// off the screen gives a single error event instead. Events leave the output
// register at one per cycle while out_ready is high and writes are queued.
// The front end builds one write per cycle while the queue has room; a number
// is first broken into decimal digits (up to 5), one at a time, in the
// divide-by-ten step, overlapped with events of earlier requests draining from
// the write queue. Requests that give no events (unused code, CGRAM slot of 8
// or more) push no writes.
module char_lcd_write_sequencer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  op,
  input  wire logic [7:0]  byte_value,
  input  wire logic [7:0]  column,
  input  wire logic [7:0]  row,
  input  wire logic [63:0] pattern,
  input  wire logic [7:0]  slot,
  input  wire logic [15:0] number,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             reg_select,
  output logic [7:0]       bus_byte,
  output logic             enable_level,
  output logic [8:0]       hold_ms,
  output logic             bad_position,
  output logic             last
);

  logic [7:0] enable_high_ms;
  logic [7:0] settle_ms;
  logic [7:0] clear_extra_ms;

  logic           push_valid;
  logic           push_ready;
  lcdws_pkg::wr_t push_data;
  logic           pop_valid;
  logic           pop_ready;
  lcdws_pkg::wr_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_high_ms <= lcdws_pkg::ENABLE_HIGH_RESET;
      settle_ms      <= lcdws_pkg::SETTLE_RESET;
      clear_extra_ms <= lcdws_pkg::CLEAR_EXTRA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lcdws_pkg::CFG_ENABLE_HIGH: enable_high_ms <= cfg_data;
        lcdws_pkg::CFG_SETTLE:      settle_ms      <= cfg_data;
        lcdws_pkg::CFG_CLEAR_EXTRA: clear_extra_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  lcdws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .byte_value (byte_value),
    .column     (column),
    .row        (row),
    .pattern    (pattern),
    .slot       (slot),
    .number     (number),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  lcdws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  lcdws_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (pop_valid),
    .q_ready        (pop_ready),
    .q_data         (pop_data),
    .enable_high_ms (enable_high_ms),
    .settle_ms      (settle_ms),
    .clear_extra_ms (clear_extra_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .reg_select     (reg_select),
    .bus_byte       (bus_byte),
    .enable_level   (enable_level),
    .hold_ms        (hold_ms),
    .bad_position   (bad_position),
    .last           (last)
  );

`ifndef SYNTHESIS
  a_bad_event_quiet : assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_position |-> last && !enable_level && !reg_select &&
      hold_ms == 9'd0 && bus_byte == 8'd0)
    else $error("bad position event drives pins");

  a_high_not_last : assert property (@(posedge clk) disable iff (rst)
    out_valid && enable_level |-> !last && !bad_position)
    else $error("enable high event marked last");

  a_low_follows_high : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && enable_level |=>
      out_valid && !enable_level && bus_byte == $past(bus_byte) &&
      reg_select == $past(reg_select))
    else $error("enable low event does not follow enable high");
`endif

endmodule
`default_nettype wire

### hw/rtl/lcdws_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LCD write sequencer front end
// Accepts requests, splits them into bus writes and pushes one write per cycle
// into the queue while it has room. Numbers first become decimal digits.
// ----------------------------------------------------------------------------
module lcdws_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        op,
  input  wire logic [7:0]        byte_value,
  input  wire logic [7:0]        column,
  input  wire logic [7:0]        row,
  input  wire logic [63:0]       pattern,
  input  wire logic [7:0]        slot,
  input  wire logic [15:0]       number,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output lcdws_pkg::wr_t         push_data
);

  lcdws_pkg::front_state_t state, state_next;

  logic [2:0]  cur_op;
  logic [7:0]  cur_byte;
  logic [7:0]  cur_col;
  logic [7:0]  cur_row;
  logic [63:0] cur_pattern;
  logic [7:0]  cur_slot;
  logic [15:0] num;
  logic [3:0]  digits [5];
  logic [2:0]  ndig;
  logic [3:0]  idx;

  logic [32:0] prod;
  logic [15:0] quot;
  logic [3:0]  rem;
  logic        digits_done;

  logic        empty;
  logic [3:0]  total;
  logic [2:0]  digit_pos;
  logic [2:0]  pat_pos;
  logic        done;
  logic        accept;

  assign prod        = {1'b0, num} * {16'd0, lcdws_pkg::DIV10_MUL};
  assign quot        = 16'(prod >> lcdws_pkg::DIV10_SHIFT);
  assign rem         = 4'(num - (quot << 3) - (quot << 1));
  assign digits_done = (quot == 16'd0) || (ndig == lcdws_pkg::NUM_DIGITS - 3'd1);

  assign digit_pos = 3'(ndig - 3'd1 - idx[2:0]);
  assign pat_pos   = 3'(idx - 4'd1);

  always_comb begin
    empty          = 1'b0;
    total          = 4'd1;
    push_data.rs    = 1'b0;
    push_data.data  = cur_byte;
    push_data.extra = 1'b0;
    push_data.bad   = 1'b0;
    case (lcdws_pkg::op_t'(cur_op))
      lcdws_pkg::OP_COMMAND: begin
        push_data.rs = 1'b0;
      end
      lcdws_pkg::OP_DATA: begin
        push_data.rs = 1'b1;
      end
      lcdws_pkg::OP_GOTO: begin
        if (cur_col < lcdws_pkg::SCREEN_COLS && cur_row == 8'd0) begin
          push_data.data = {lcdws_pkg::ROW0_BASE_HI, cur_col[3:0]};
        end else if (cur_col < lcdws_pkg::SCREEN_COLS && cur_row == 8'd1) begin
          push_data.data = {lcdws_pkg::ROW1_BASE_HI, cur_col[3:0]};
        end else begin
          push_data.data = 8'd0;
          push_data.bad  = 1'b1;
        end
      end
      lcdws_pkg::OP_CLEAR: begin
        total = 4'd2;
        push_data.data = (idx == 4'd0) ? lcdws_pkg::CMD_CLEAR : lcdws_pkg::CMD_SET_DDRAM;
      end
      lcdws_pkg::OP_INIT: begin
        total = 4'd5;
        case (idx)
          4'd0:    push_data.data = lcdws_pkg::CMD_FUNCTION_SET;
          4'd1:    push_data.data = lcdws_pkg::CMD_DISPLAY_ON;
          4'd2:    push_data.data = lcdws_pkg::CMD_ENTRY_MODE;
          4'd3: begin
            push_data.data  = lcdws_pkg::CMD_CLEAR;
            push_data.extra = 1'b1;
          end
          default: push_data.data = lcdws_pkg::CMD_SET_DDRAM;
        endcase
      end
      lcdws_pkg::OP_CGRAM: begin
        total = 4'd9;
        empty = cur_slot >= lcdws_pkg::CGRAM_SLOTS;
        if (idx == 4'd0) begin
          push_data.data = {lcdws_pkg::CGRAM_BASE_HI, cur_slot[2:0], 3'b000};
        end else begin
          push_data.rs   = 1'b1;
          push_data.data = cur_pattern[8 * pat_pos +: 8];
        end
      end
      lcdws_pkg::OP_NUMBER: begin
        total          = {1'b0, ndig};
        push_data.rs   = 1'b1;
        push_data.data = lcdws_pkg::ASCII_ZERO | {4'd0, digits[digit_pos]};
      end
      default: begin
        empty = 1'b1;
      end
    endcase
    push_data.last = (idx == total - 4'd1) || push_data.bad;
  end

  assign push_valid = (state == lcdws_pkg::FR_EMIT) && !empty;
  assign done       = (state == lcdws_pkg::FR_EMIT) &&
                      (empty || (push_ready && push_data.last));
  assign in_ready   = (state == lcdws_pkg::FR_IDLE) || done;
  assign accept     = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      lcdws_pkg::FR_IDLE: begin
        if (accept) begin
          state_next = (lcdws_pkg::op_t'(op) == lcdws_pkg::OP_NUMBER) ?
                       lcdws_pkg::FR_DIGITS : lcdws_pkg::FR_EMIT;
        end
      end
      lcdws_pkg::FR_DIGITS: begin
        if (digits_done) begin
          state_next = lcdws_pkg::FR_EMIT;
        end
      end
      lcdws_pkg::FR_EMIT: begin
        if (accept) begin
          state_next = (lcdws_pkg::op_t'(op) == lcdws_pkg::OP_NUMBER) ?
                       lcdws_pkg::FR_DIGITS : lcdws_pkg::FR_EMIT;
        end else if (done) begin
          state_next = lcdws_pkg::FR_IDLE;
        end
      end
      default: state_next = lcdws_pkg::FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcdws_pkg::FR_IDLE;
      ndig  <= 3'd0;
      idx   <= 4'd0;
    end else begin
      state <= state_next;
      if (accept) begin
        ndig <= 3'd0;
        idx  <= 4'd0;
      end else begin
        if (state == lcdws_pkg::FR_DIGITS) begin
          ndig <= ndig + 3'd1;
        end
        if (push_valid && push_ready) begin
          idx <= idx + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op      <= op;
      cur_byte    <= byte_value;
      cur_col     <= column;
      cur_row     <= row;
      cur_pattern <= pattern;
      cur_slot    <= slot;
      num         <= number;
    end else if (state == lcdws_pkg::FR_DIGITS) begin
      num          <= quot;
      digits[ndig] <= rem;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/lcdws_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LCD write sequencer queue
// Small first-in first-out store of bus writes between front end and
// event generator.
// ----------------------------------------------------------------------------
module lcdws_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire lcdws_pkg::wr_t wr_data,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output lcdws_pkg::wr_t      rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  lcdws_pkg::wr_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_wr;
  logic           do_rd;

  assign wr_ready = count != FULL_CNT;
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/lcdws_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LCD write sequencer event generator
// Turns each queued bus write into an enable-high and an enable-low event,
// or one error event for a bad position, and holds it in an output register.
// ----------------------------------------------------------------------------
module lcdws_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  output logic                q_ready,
  input  wire lcdws_pkg::wr_t q_data,
  input  wire logic [7:0]     enable_high_ms,
  input  wire logic [7:0]     settle_ms,
  input  wire logic [7:0]     clear_extra_ms,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                reg_select,
  output logic [7:0]          bus_byte,
  output logic                enable_level,
  output logic [8:0]          hold_ms,
  output logic                bad_position,
  output logic                last
);

  lcdws_pkg::wr_t cur;
  logic           cur_valid;
  logic           phase;
  logic           load;
  logic           finish;

  assign load    = cur_valid && (!out_valid || out_ready);
  assign finish  = load && (phase || cur.bad);
  assign q_ready = !cur_valid || finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_ready) begin
        cur_valid <= q_valid;
        phase     <= 1'b0;
      end else if (load) begin
        phase <= 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_valid) begin
      cur <= q_data;
    end
    if (load) begin
      if (cur.bad) begin
        reg_select   <= 1'b0;
        bus_byte     <= 8'd0;
        enable_level <= 1'b0;
        hold_ms      <= 9'd0;
        bad_position <= 1'b1;
        last         <= 1'b1;
      end else if (!phase) begin
        reg_select   <= cur.rs;
        bus_byte     <= cur.data;
        enable_level <= 1'b1;
        hold_ms      <= {1'b0, enable_high_ms};
        bad_position <= 1'b0;
        last         <= 1'b0;
      end else begin
        reg_select   <= cur.rs;
        bus_byte     <= cur.data;
        enable_level <= 1'b0;
        hold_ms      <= {1'b0, settle_ms} + (cur.extra ? {1'b0, clear_extra_ms} : 9'd0);
        bad_position <= 1'b0;
        last         <= cur.last;
      end
    end
  end

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Character LCD write sequencer testbench
// Drives requests into the sequencer over a valid/ready channel. A tracker
// builds the expected pin events of each accepted request from its own copy
// of the timing registers and checks each event that leaves the block in
// order. The run steps through register settings and idling phases: a
// directed opening, then random requests.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [2:0] OP_UNUSED   = 3'd7;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         QUIET_GAP   = 30;
  localparam int         LONG_HOLD   = 400;

  typedef struct packed {
    logic       rs;
    logic [7:0] data;
    logic       en;
    logic [8:0] hold;
    logic       bad;
    logic       fin;
  } pin_event_t;

  class pin_event_tracker;
    pin_event_t pending[$];
    pin_event_t staged[$];
    logic [7:0] enable_high;
    logic [7:0] settle;
    logic [7:0] clear_extra;
    int         errors;

    function new();
      enable_high = lcdws_pkg::ENABLE_HIGH_RESET;
      settle      = lcdws_pkg::SETTLE_RESET;
      clear_extra = lcdws_pkg::CLEAR_EXTRA_RESET;
      errors      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        lcdws_pkg::CFG_ENABLE_HIGH: enable_high = val;
        lcdws_pkg::CFG_SETTLE:      settle = val;
        lcdws_pkg::CFG_CLEAR_EXTRA: clear_extra = val;
        default: ;
      endcase
    endfunction

    function void add_write(logic rs, logic [7:0] data, logic [7:0] extra);
      pin_event_t e;
      e = '0;
      e.rs = rs;
      e.data = data;
      e.en = 1'b1;
      e.hold = {1'b0, enable_high};
      staged.push_back(e);
      e.en = 1'b0;
      e.hold = {1'b0, settle} + {1'b0, extra};
      staged.push_back(e);
    endfunction

    function void note_request(logic [2:0] req_op, logic [7:0] bval, logic [7:0] col,
                               logic [7:0] line, logic [63:0] glyph, logic [7:0] slt,
                               logic [15:0] num);
      pin_event_t  e;
      logic [15:0] digits [0:4];
      logic [15:0] rest;
      int          cnt;
      staged.delete();
      case (req_op)
        lcdws_pkg::OP_COMMAND: add_write(1'b0, bval, 8'd0);
        lcdws_pkg::OP_DATA:    add_write(1'b1, bval, 8'd0);
        lcdws_pkg::OP_GOTO: begin
          if (col < lcdws_pkg::SCREEN_COLS && line == 8'd0)
            add_write(1'b0, {lcdws_pkg::ROW0_BASE_HI, col[3:0]}, 8'd0);
          else if (col < lcdws_pkg::SCREEN_COLS && line == 8'd1)
            add_write(1'b0, {lcdws_pkg::ROW1_BASE_HI, col[3:0]}, 8'd0);
          else begin
            e = '0;
            e.bad = 1'b1;
            staged.push_back(e);
          end
        end
        lcdws_pkg::OP_CLEAR: begin
          add_write(1'b0, lcdws_pkg::CMD_CLEAR, 8'd0);
          add_write(1'b0, lcdws_pkg::CMD_SET_DDRAM, 8'd0);
        end
        lcdws_pkg::OP_INIT: begin
          add_write(1'b0, lcdws_pkg::CMD_FUNCTION_SET, 8'd0);
          add_write(1'b0, lcdws_pkg::CMD_DISPLAY_ON, 8'd0);
          add_write(1'b0, lcdws_pkg::CMD_ENTRY_MODE, 8'd0);
          add_write(1'b0, lcdws_pkg::CMD_CLEAR, clear_extra);
          add_write(1'b0, lcdws_pkg::CMD_SET_DDRAM, 8'd0);
        end
        lcdws_pkg::OP_CGRAM: begin
          if (slt < lcdws_pkg::CGRAM_SLOTS) begin
            add_write(1'b0, 8'h40 | {2'b00, slt[2:0], 3'b000}, 8'd0);
            for (int i = 0; i < 8; i++)
              add_write(1'b1, glyph[8*i +: 8], 8'd0);
          end
        end
        lcdws_pkg::OP_NUMBER: begin
          rest = num;
          cnt = 0;
          do begin
            digits[cnt] = rest % 16'd10;
            rest = rest / 16'd10;
            cnt++;
          end while (rest != 0 && cnt < 5);
          for (int i = cnt - 1; i >= 0; i--)
            add_write(1'b1, lcdws_pkg::ASCII_ZERO + digits[i][7:0], 8'd0);
        end
        default: ;
      endcase
      if (staged.size() > 0) begin
        e = staged.pop_back();
        e.fin = 1'b1;
        staged.push_back(e);
      end
      foreach (staged[i])
        pending.push_back(staged[i]);
    endfunction

    function void compare_field(string field, logic [8:0] want, logic [8:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    function void check_event(logic rs, logic [7:0] data, logic en, logic [8:0] hold,
                              logic bad, logic fin);
      pin_event_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: pin event with none expected, expected nothing, got byte %0h",
                 $time, data);
        return;
      end
      want = pending.pop_front();
      compare_field("reg_select", {8'd0, want.rs}, {8'd0, rs});
      compare_field("bus_byte", {1'b0, want.data}, {1'b0, data});
      compare_field("enable_level", {8'd0, want.en}, {8'd0, en});
      compare_field("hold_ms", want.hold, hold);
      compare_field("bad_position", {8'd0, want.bad}, {8'd0, bad});
      compare_field("last", {8'd0, want.fin}, {8'd0, fin});
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  op;
  logic [7:0]  byte_value;
  logic [7:0]  column;
  logic [7:0]  row;
  logic [63:0] pattern;
  logic [7:0]  slot;
  logic [15:0] number;
  logic        out_valid;
  logic        out_ready;
  logic        reg_select;
  logic [7:0]  bus_byte;
  logic        enable_level;
  logic [8:0]  hold_ms;
  logic        bad_position;
  logic        last;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_off;
  int cycles;

  pin_event_tracker board;

  char_lcd_write_sequencer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .byte_value   (byte_value),
    .column       (column),
    .row          (row),
    .pattern      (pattern),
    .slot         (slot),
    .number       (number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .reg_select   (reg_select),
    .bus_byte     (bus_byte),
    .enable_level (enable_level),
    .hold_ms      (hold_ms),
    .bad_position (bad_position),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // receiver: long hold-off when asked, otherwise random stalls
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_event(reg_select, bus_byte, enable_level, hold_ms, bad_position, last);
  end

  task automatic send_item(input logic [2:0] o, input logic [7:0] b, input logic [7:0] c,
                           input logic [7:0] r, input logic [63:0] p, input logic [7:0] s,
                           input logic [15:0] n);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    op         <= o;
    byte_value <= b;
    column     <= c;
    row        <= r;
    pattern    <= p;
    slot       <= s;
    number     <= n;
    do @(posedge clk); while (!in_ready);
    board.note_request(o, b, c, r, p, s, n);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [2:0]  o;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  r;
    logic [7:0]  s;
    logic [63:0] p;
    logic [15:0] n;
    int          pick;
    pick = $urandom_range(99);
    b = 8'($urandom);
    c = 8'($urandom);
    r = 8'($urandom);
    s = 8'($urandom);
    p = {$urandom, $urandom};
    n = 16'($urandom);
    if (pick < 12)      o = lcdws_pkg::OP_COMMAND;
    else if (pick < 30) o = lcdws_pkg::OP_DATA;
    else if (pick < 46) o = lcdws_pkg::OP_GOTO;
    else if (pick < 54) o = lcdws_pkg::OP_CLEAR;
    else if (pick < 62) o = lcdws_pkg::OP_INIT;
    else if (pick < 76) o = lcdws_pkg::OP_CGRAM;
    else if (pick < 97) o = lcdws_pkg::OP_NUMBER;
    else                o = OP_UNUSED;
    if (o == lcdws_pkg::OP_GOTO && $urandom_range(3) != 0) begin
      c = 8'($urandom_range(15));
      r = 8'($urandom_range(1));
    end
    if (o == lcdws_pkg::OP_CGRAM && $urandom_range(4) != 0)
      s = 8'($urandom_range(7));
    if (o == lcdws_pkg::OP_NUMBER) begin
      case ($urandom_range(3))
        0: n = 16'($urandom_range(9));
        1: n = 16'($urandom_range(999));
        default: ;
      endcase
    end
    send_item(o, b, c, r, p, s, n);
  endtask

  // hold the input idle until every expected event is out, then let the
  // front end settle
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (QUIET_GAP) @(negedge clk);
  endtask

  task automatic configure(input logic [7:0] eh, input logic [7:0] st, input logic [7:0] ce);
    cfg_we    <= 1'b1;
    cfg_index <= lcdws_pkg::CFG_ENABLE_HIGH;
    cfg_data  <= eh;
    @(negedge clk);
    cfg_index <= lcdws_pkg::CFG_SETTLE;
    cfg_data  <= st;
    @(negedge clk);
    cfg_index <= lcdws_pkg::CFG_CLEAR_EXTRA;
    cfg_data  <= ce;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_reg(lcdws_pkg::CFG_ENABLE_HIGH, eh);
    board.set_reg(lcdws_pkg::CFG_SETTLE, st);
    board.set_reg(lcdws_pkg::CFG_CLEAR_EXTRA, ce);
  endtask

  task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random();
    drain();
  endtask

  initial begin
    board          = new();
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = lcdws_pkg::CFG_ENABLE_HIGH;
    cfg_data       = 8'd0;
    in_valid       = 1'b0;
    op             = lcdws_pkg::OP_COMMAND;
    byte_value     = 8'd0;
    column         = 8'd0;
    row            = 8'd0;
    pattern        = 64'd0;
    slot           = 8'd0;
    number         = 16'd0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off       = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item(lcdws_pkg::OP_COMMAND, 8'h00, 8'd0, 8'd0, 64'd0, 8'd0, 16'd0);
    send_item(lcdws_pkg::OP_COMMAND, 8'hFF, 8'd0, 8'd0, 64'd0, 8'd0, 16'd0);
    send_item(lcdws_pkg::OP_DATA, 8'h00, 8'd0, 8'd0, 64'd0, 8'd0, 16'd0);
    send_item(lcdws_pkg::OP_DATA, 8'hFF, 8'd0, 8'd0, 64'd0, 8'd0, 16'd0);
    send_item(lcdws_pkg::OP_GOTO, 8'd0, 8'd0, 8'd0, 64'd0, 8'd0, 16'd0);
    send_item(lcdws_pkg::OP_GOTO, 8'd0, 8'd15, 8'd1, 64'd0, 8'd0, 16'd0);
    send_item(lcdws_pkg::OP_GOTO, 8'd0, 8'd16, 8'd0, 64'd0, 8'd0, 16'd0);
    send_item(lcdws_pkg::OP_GOTO, 8'd0, 8'd0, 8'd2, 64'd0, 8'd0, 16'd0);
    send_item(lcdws_pkg::OP_GOTO, 8'd0, 8'd255, 8'd255, 64'd0, 8'd0, 16'd0);
    send_item(lcdws_pkg::OP_CLEAR, 8'd0, 8'd0, 8'd0, 64'd0, 8'd0, 16'd0);
    send_item(lcdws_pkg::OP_INIT, 8'd0, 8'd0, 8'd0, 64'd0, 8'd0, 16'd0);
    send_item(lcdws_pkg::OP_CGRAM, 8'd0, 8'd0, 8'd0, {64{1'b1}}, 8'd0, 16'd0);
    send_item(lcdws_pkg::OP_CGRAM, 8'd0, 8'd0, 8'd0, 64'h0123_4567_89AB_CDEF, 8'd7,
              16'd0);
    send_item(lcdws_pkg::OP_CGRAM, 8'd0, 8'd0, 8'd0, 64'h0123_4567_89AB_CDEF, 8'd8,
              16'd0);
    send_item(lcdws_pkg::OP_CGRAM, 8'd0, 8'd0, 8'd0, 64'd0, 8'd255, 16'd0);
    send_item(lcdws_pkg::OP_NUMBER, 8'd0, 8'd0, 8'd0, 64'd0, 8'd0, 16'd0);
    send_item(lcdws_pkg::OP_NUMBER, 8'd0, 8'd0, 8'd0, 64'd0, 8'd0, 16'd9);
    send_item(lcdws_pkg::OP_NUMBER, 8'd0, 8'd0, 8'd0, 64'd0, 8'd0, 16'd10);
    send_item(lcdws_pkg::OP_NUMBER, 8'd0, 8'd0, 8'd0, 64'd0, 8'd0, 16'd10000);
    send_item(lcdws_pkg::OP_NUMBER, 8'd0, 8'd0, 8'd0, 64'd0, 8'd0, 16'd65535);
    send_item(OP_UNUSED, 8'd0, 8'd0, 8'd0, 64'd0, 8'd0, 16'd0);
    drain();

    configure(8'd0, 8'd0, 8'd0);
    run_phase(60, 0, 0);

    configure(8'd255, 8'd255, 8'd255);
    run_phase(60, 72, 0);

    configure(8'($urandom), 8'($urandom), 8'($urandom));
    hold_off = LONG_HOLD;
    run_phase(60, 0, 72);

    configure(8'($urandom), 8'($urandom), 8'($urandom));
    run_phase(70, 27, 27);

    configure(8'd1, 8'd255, 8'd0);
    run_phase(60, 0, 0);

    repeat (QUIET_GAP) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
